[hw/rtl/mcws_pkg.sv]
// shared widths, depths and command codes of the minimum covering window search
`default_nettype none
package mcws_pkg;

  localparam int TEXT_DEPTH_DEF    = 128;
  localparam int PATTERN_DEPTH_DEF = 128;

  localparam int FUNC_W  = 2;
  localparam int BYTE_W  = 8;
  localparam int INDEX_W = 7;
  localparam int SYMBOLS = 256;

  localparam logic [FUNC_W-1:0] FUNC_TEXT    = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_PATTERN = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_SEARCH  = 2'd2;

endpackage
`default_nettype wire

[hw/rtl/mcws_req_if.sv]
// request channel: command word with func and byte_value
`default_nettype none
interface mcws_req_if import mcws_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [FUNC_W-1:0] func;
  logic [BYTE_W-1:0] byte_value;

  modport src (output valid, output func, output byte_value, input ready);
  modport snk (input valid, input func, input byte_value, output ready);
  modport mon (input valid, input func, input byte_value, input ready);
endinterface
`default_nettype wire

[hw/rtl/mcws_rsp_if.sv]
// response channel: search result word
`default_nettype none
interface mcws_rsp_if import mcws_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               found;
  logic [INDEX_W-1:0] window_start;
  logic [INDEX_W-1:0] window_end;
  logic               overflow;

  modport src (output valid, output found, output window_start, output window_end,
               output overflow, input ready);
  modport snk (input valid, input found, input window_start, input window_end,
               input overflow, output ready);
  modport mon (input valid, input found, input window_start, input window_end,
               input overflow, input ready);
endinterface
`default_nettype wire

[hw/rtl/minimum_covering_window_search_core.sv]
// top level: text store, shared count memory and two-pointer search sequencer
//
// channel  dir  word                                         accepted when
// req      in   func, byte_value                             valid & ready
// rsp      out  found, window_start, window_end, overflow    valid & ready
//
// text word: written straight into the text store; pattern word: read-modify-write of the count memory
// search: each right step and each left step reads the text, then reads and updates the count memory,
// whose one read port and one write port are shared by both pointers
// req.ready is low while a pattern update or a search runs; a held result stalls the next
// search in its done state, and req.ready stays low until the result slot is free
// synchronous reset; counts clear through per-symbol valid bits
`default_nettype none
module minimum_covering_window_search_core import mcws_pkg::*; #(
  parameter int TEXT_DEPTH    = TEXT_DEPTH_DEF,
  parameter int PATTERN_DEPTH = PATTERN_DEPTH_DEF
) (
  input  wire logic clk,
  input  wire logic rst,
  mcws_req_if.snk   req,
  mcws_rsp_if.src   rsp
);

  localparam int IW   = $clog2(TEXT_DEPTH);
  localparam int LW   = $clog2(TEXT_DEPTH + 1);
  localparam int PLW  = $clog2(PATTERN_DEPTH + 1);
  localparam int MAXD = (TEXT_DEPTH > PATTERN_DEPTH) ? TEXT_DEPTH : PATTERN_DEPTH;
  localparam int CW   = $clog2(MAXD + 1) + 1;

  typedef enum logic [8:0] {
    S_IDLE   = 9'b000000001,
    S_P_UPD  = 9'b000000010,
    S_R_RD   = 9'b000000100,
    S_R_WAIT = 9'b000001000,
    S_R_UPD  = 9'b000010000,
    S_L_CHK  = 9'b000100000,
    S_L_WAIT = 9'b001000000,
    S_L_UPD  = 9'b010000000,
    S_DONE   = 9'b100000000
  } state_t;

  state_t state;

  logic [BYTE_W-1:0] text_mem [TEXT_DEPTH];
  logic [BYTE_W-1:0] text_q;
  logic [IW-1:0]     text_raddr;

  logic signed [CW-1:0] need_mem [SYMBOLS];
  logic [SYMBOLS-1:0]   need_vld;
  logic signed [CW-1:0] need_q;
  logic                 need_vq;
  logic signed [CW-1:0] need_eff;
  logic signed [CW-1:0] need_wdata;
  logic [BYTE_W-1:0]    need_raddr;
  logic [BYTE_W-1:0]    need_waddr;
  logic                 need_we;

  logic [LW-1:0]  text_length;
  logic [PLW-1:0] pattern_length;
  logic           overflow_seen;

  logic [LW-1:0]  right;
  logic [LW-1:0]  left;
  logic [PLW-1:0] missing;
  logic [LW:0]    best_len;
  logic [LW:0]    cur_len;
  logic [LW-1:0]  best_start;
  logic [LW-1:0]  best_end;
  logic           found;

  logic accept;
  logic slot_free;

  assign req.ready = (state == S_IDLE);
  assign accept    = req.valid && req.ready;
  assign slot_free = !rsp.valid || rsp.ready;

  always_comb begin
    text_raddr = (state == S_R_RD) ? right[IW-1:0] : left[IW-1:0];
    need_raddr = (state == S_IDLE) ? req.byte_value : text_q;
    need_eff   = need_vq ? need_q : '0;
    need_we    = (state == S_P_UPD) || (state == S_R_UPD) || (state == S_L_UPD);
    need_wdata = (state == S_R_UPD) ? need_eff - CW'(1) : need_eff + CW'(1);
    cur_len    = {1'b0, right} - {1'b0, left} + (LW+1)'(1);
  end

  // text store
  always_ff @(posedge clk) begin
    if (accept && req.func == FUNC_TEXT && text_length < LW'(TEXT_DEPTH)) begin
      text_mem[text_length[IW-1:0]] <= req.byte_value;
    end
    text_q <= text_mem[text_raddr];
  end

  // pattern minus window count per symbol
  always_ff @(posedge clk) begin
    if (need_we) begin
      need_mem[need_waddr] <= need_wdata;
    end
    need_q  <= need_mem[need_raddr];
    need_vq <= need_vld[need_raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      need_vld <= '0;
    end else if (state == S_DONE && slot_free) begin
      need_vld <= '0;
    end else if (need_we) begin
      need_vld[need_waddr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      text_length    <= '0;
      pattern_length <= '0;
      overflow_seen  <= 1'b0;
      rsp.valid      <= 1'b0;
    end else begin
      if (rsp.valid && rsp.ready && state != S_DONE) begin
        rsp.valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            case (req.func)
              FUNC_TEXT: begin
                if (text_length < LW'(TEXT_DEPTH)) begin
                  text_length <= text_length + LW'(1);
                end else begin
                  overflow_seen <= 1'b1;
                end
              end
              FUNC_PATTERN: begin
                if (pattern_length < PLW'(PATTERN_DEPTH)) begin
                  pattern_length <= pattern_length + PLW'(1);
                  need_waddr     <= req.byte_value;
                  state          <= S_P_UPD;
                end else begin
                  overflow_seen <= 1'b1;
                end
              end
              FUNC_SEARCH: begin
                right      <= '0;
                left       <= '0;
                missing    <= pattern_length;
                best_len   <= {1'b0, text_length} + (LW+1)'(1);
                best_start <= '0;
                best_end   <= '0;
                if (text_length == '0) begin
                  found <= 1'b0;
                  state <= S_DONE;
                end else if (pattern_length == '0) begin
                  found <= 1'b1;
                  state <= S_DONE;
                end else begin
                  found <= 1'b0;
                  state <= S_R_RD;
                end
              end
              default: begin
              end
            endcase
          end
        end
        S_P_UPD: begin
          state <= S_IDLE;
        end
        S_R_RD: begin
          state <= (right == text_length) ? S_DONE : S_R_WAIT;
        end
        S_R_WAIT: begin
          need_waddr <= text_q;
          state      <= S_R_UPD;
        end
        S_R_UPD: begin
          if (!need_eff[CW-1] && need_eff != '0) begin
            missing <= missing - PLW'(1);
          end
          state <= S_L_CHK;
        end
        S_L_CHK: begin
          if (missing == '0 && left <= right) begin
            if (cur_len < best_len) begin
              best_len   <= cur_len;
              best_start <= left;
              best_end   <= right;
              found      <= 1'b1;
            end
            state <= S_L_WAIT;
          end else begin
            right <= right + LW'(1);
            state <= S_R_RD;
          end
        end
        S_L_WAIT: begin
          need_waddr <= text_q;
          state      <= S_L_UPD;
        end
        S_L_UPD: begin
          if (!need_wdata[CW-1] && need_wdata != '0) begin
            missing <= missing + PLW'(1);
          end
          left  <= left + LW'(1);
          state <= S_L_CHK;
        end
        S_DONE: begin
          if (slot_free) begin
            rsp.valid        <= 1'b1;
            rsp.found        <= found;
            rsp.window_start <= INDEX_W'(best_start);
            rsp.window_end   <= INDEX_W'(best_end);
            rsp.overflow     <= overflow_seen;
            text_length      <= '0;
            pattern_length   <= '0;
            overflow_seen    <= 1'b0;
            state            <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

[hw/rtl/mcws_checker.sv]
// port-level assertions on the search core and their bind
`default_nettype none
module mcws_checker import mcws_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               rsp_valid,
  input  wire logic               rsp_ready,
  input  wire logic               rsp_found,
  input  wire logic [INDEX_W-1:0] rsp_window_start,
  input  wire logic [INDEX_W-1:0] rsp_window_end,
  input  wire logic               rsp_overflow
);

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid)
    else $error("rsp word dropped while stalled");

  a_rsp_stable: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> $stable(rsp_found) && $stable(rsp_window_start)
      && $stable(rsp_window_end) && $stable(rsp_overflow))
    else $error("rsp word changed while stalled");

  a_none_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_found |-> rsp_window_start == '0 && rsp_window_end == '0)
    else $error("window indices set without a match");

  a_order: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_found |-> rsp_window_start <= rsp_window_end)
    else $error("window start after window end");

  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !rsp_valid)
    else $error("rsp valid right after reset");

endmodule

bind minimum_covering_window_search_core mcws_checker u_mcws_checker (
  .clk              (clk),
  .rst              (rst),
  .rsp_valid        (rsp.valid),
  .rsp_ready        (rsp.ready),
  .rsp_found        (rsp.found),
  .rsp_window_start (rsp.window_start),
  .rsp_window_end   (rsp.window_end),
  .rsp_overflow     (rsp.overflow)
);
`default_nettype wire

[sim/testbench.sv]
`timescale 1ns / 1ps
// testbench for the minimum covering window search core: random text and pattern jobs
module testbench;
  import mcws_pkg::*;

  localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;
  localparam int HOLD_CYCLES = 400;
  localparam int IDLE_LIMIT  = 5000;
  localparam int DRAIN_WAIT  = 1000;
  localparam int ITEM_TARGET = 1000;

  typedef struct packed {
    logic               found;
    logic [INDEX_W-1:0] win_first;
    logic [INDEX_W-1:0] win_last;
    logic               overflow;
  } window_word_t;

  class window_scoreboard;
    logic [BYTE_W-1:0] text_bytes[TEXT_DEPTH_DEF];
    int text_count;
    int pattern_hist[SYMBOLS];
    int pattern_count;
    bit dropped;
    window_word_t expected_q[$];
    int errors, searches, hits, overflows, longest_text;

    function new();
      clear_store();
    endfunction

    function void clear_store();
      foreach (pattern_hist[i]) pattern_hist[i] = 0;
      text_count = 0;
      pattern_count = 0;
      dropped = 0;
    endfunction

    function window_word_t cover_window();
      window_word_t w;
      int have[SYMBOLS];
      int missing, best, lo;
      w = '0;
      w.overflow = dropped;
      if (text_count == 0) return w;
      if (pattern_count == 0) begin
        w.found = 1'b1;
        return w;
      end
      foreach (have[i]) have[i] = 0;
      missing = pattern_count;
      best = text_count + 1;
      lo = 0;
      for (int hi = 0; hi < text_count; hi++) begin
        if (have[text_bytes[hi]] < pattern_hist[text_bytes[hi]]) missing--;
        have[text_bytes[hi]]++;
        while (missing == 0 && lo <= hi) begin
          if (hi - lo + 1 < best) begin
            best = hi - lo + 1;
            w.found = 1'b1;
            w.win_first = INDEX_W'(lo);
            w.win_last = INDEX_W'(hi);
          end
          have[text_bytes[lo]]--;
          if (have[text_bytes[lo]] < pattern_hist[text_bytes[lo]]) missing++;
          lo++;
        end
      end
      return w;
    endfunction

    function void note_word(logic [FUNC_W-1:0] f, logic [BYTE_W-1:0] b);
      window_word_t w;
      case (f)
        FUNC_TEXT: begin
          if (text_count < TEXT_DEPTH_DEF) begin
            text_bytes[text_count] = b;
            text_count++;
            if (text_count > longest_text) longest_text = text_count;
          end else begin
            dropped = 1'b1;
          end
        end
        FUNC_PATTERN: begin
          if (pattern_count < PATTERN_DEPTH_DEF) begin
            pattern_hist[b]++;
            pattern_count++;
          end else begin
            dropped = 1'b1;
          end
        end
        FUNC_SEARCH: begin
          w = cover_window();
          expected_q.push_back(w);
          searches++;
          if (w.found) hits++;
          if (w.overflow) overflows++;
          clear_store();
        end
        default: ;
      endcase
    endfunction

    function void compare_field(string name, logic [INDEX_W-1:0] want, logic [INDEX_W-1:0] got);
      if (got !== want) begin
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        errors++;
      end
    endfunction

    function void check_result(window_word_t got);
      window_word_t want;
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result word, expected none, actual %p", $time, got);
        errors++;
        return;
      end
      want = expected_q.pop_front();
      compare_field("found", INDEX_W'(want.found), INDEX_W'(got.found));
      compare_field("window_start", want.win_first, got.win_first);
      compare_field("window_end", want.win_last, got.win_last);
      compare_field("overflow", INDEX_W'(want.overflow), INDEX_W'(got.overflow));
    endfunction
  endclass

  logic clk;
  logic rst;
  mcws_req_if req ();
  mcws_rsp_if rsp ();

  window_scoreboard board = new();
  bit quiet;
  bit idle_on;
  bit hold_request;
  int sent;

  minimum_covering_window_search_core DUT (
    .clk(clk),
    .rst(rst),
    .req(req),
    .rsp(rsp)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    if (!rst && rsp.valid && rsp.ready)
      board.check_result(window_word_t'({rsp.found, rsp.window_start, rsp.window_end,
                                         rsp.overflow}));
  end

  // result side: random stall bursts and ready runs, one long hold-off on request
  initial begin
    rsp.ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (hold_request) begin
        rsp.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_request = 1'b0;
      end else if (!quiet && $urandom_range(0, 4) == 0) begin
        rsp.ready <= 1'b0;
        repeat ($urandom_range(1, 15)) @(posedge clk);
      end else if (!quiet && $urandom_range(0, 9) == 0) begin
        rsp.ready <= 1'b1;
        repeat (100) @(posedge clk);
      end
      rsp.ready <= 1'b1;
      @(posedge clk);
    end
  end

  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk);
      if (rst || (req.valid && req.ready) || (rsp.valid && rsp.ready)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("%0t: no word moved for %0d cycles", $time, IDLE_LIMIT);
    $display("Test completed with failures");
    $finish;
  end

  task automatic send_word(input logic [FUNC_W-1:0] f, input logic [BYTE_W-1:0] b);
    if (!quiet && idle_on && $urandom_range(0, 5) == 0) begin
      req.valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
    req.valid <= 1'b1;
    req.func <= f;
    req.byte_value <= b;
    @(posedge clk);
    while (!req.ready) @(posedge clk);
    board.note_word(f, b);
    if (f != FUNC_UNUSED) sent++;
  endtask

  task automatic drain();
    req.valid <= 1'b0;
    while (board.expected_q.size() != 0) @(posedge clk);
  endtask

  task automatic run_job(input int tlen, input int plen);
    logic [BYTE_W-1:0] alpha[4];
    logic [BYTE_W-1:0] txt[$];
    logic [BYTE_W-1:0] pat[$];
    int ti, pi, asize;
    bit wide;
    wide = ($urandom_range(0, 7) == 0);
    asize = $urandom_range(1, 4);
    foreach (alpha[i]) alpha[i] = BYTE_W'($urandom);
    for (int i = 0; i < tlen; i++)
      txt.push_back(wide ? BYTE_W'($urandom) : alpha[$urandom_range(0, asize - 1)]);
    for (int i = 0; i < plen; i++) begin
      if (txt.size() != 0 && $urandom_range(0, 4) != 0)
        pat.push_back(txt[$urandom_range(0, txt.size() - 1)]);
      else
        pat.push_back(wide ? BYTE_W'($urandom) : alpha[$urandom_range(0, asize - 1)]);
    end
    idle_on = ($urandom_range(0, 2) != 0);
    ti = 0;
    pi = 0;
    while (ti < txt.size() || pi < pat.size()) begin
      if ($urandom_range(0, 29) == 0) send_word(FUNC_UNUSED, BYTE_W'($urandom));
      if (pi >= pat.size() || (ti < txt.size() && $urandom_range(0, 1) == 0)) begin
        send_word(FUNC_TEXT, txt[ti]);
        ti++;
      end else begin
        send_word(FUNC_PATTERN, pat[pi]);
        pi++;
      end
    end
    send_word(FUNC_SEARCH, BYTE_W'($urandom));
  endtask

  initial begin
    int r;
    bit held, paused;
    held = 0;
    paused = 0;
    quiet = 0;
    idle_on = 1;
    hold_request = 0;
    sent = 0;
    rst <= 1'b1;
    req.valid <= 1'b0;
    req.func <= FUNC_TEXT;
    req.byte_value <= '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // nothing loaded
    send_word(FUNC_SEARCH, 8'h00);
    // text with empty pattern
    send_word(FUNC_TEXT, 8'hff);
    send_word(FUNC_SEARCH, 8'hff);
    // pattern with empty text
    send_word(FUNC_PATTERN, 8'h00);
    send_word(FUNC_SEARCH, 8'h5a);
    // repeated byte 255, unused selector in between
    send_word(FUNC_TEXT, 8'h00);
    send_word(FUNC_TEXT, 8'hff);
    send_word(FUNC_UNUSED, 8'hff);
    send_word(FUNC_TEXT, 8'hff);
    send_word(FUNC_PATTERN, 8'hff);
    send_word(FUNC_PATTERN, 8'hff);
    send_word(FUNC_SEARCH, 8'h00);
    // pattern needs more copies than the text holds
    send_word(FUNC_TEXT, 8'h07);
    send_word(FUNC_PATTERN, 8'h07);
    send_word(FUNC_PATTERN, 8'h07);
    send_word(FUNC_SEARCH, 8'h00);
    // tie in length, earliest start
    send_word(FUNC_TEXT, 8'h01);
    send_word(FUNC_TEXT, 8'h02);
    send_word(FUNC_TEXT, 8'h01);
    send_word(FUNC_PATTERN, 8'h01);
    send_word(FUNC_SEARCH, 8'h00);

    while (sent < ITEM_TARGET) begin
      if (!held && sent >= 300) begin
        held = 1;
        hold_request = 1'b1;
        repeat (4) run_job(3, 1);
      end
      if (!paused && sent >= 600) begin
        paused = 1;
        drain();
      end
      if (sent >= ITEM_TARGET - 150) quiet = 1;
      r = $urandom_range(0, 79);
      if (r == 0) run_job($urandom_range(125, 131), $urandom_range(1, 4));
      else if (r == 1) run_job($urandom_range(2, 20), $urandom_range(126, 130));
      else if (r == 2) run_job(0, $urandom_range(0, 3));
      else run_job($urandom_range(0, 14), $urandom_range(0, 5));
    end

    drain();
    repeat (DRAIN_WAIT) @(posedge clk);
    $display("covered %0d searches (%0d with a window, %0d with dropped bytes)",
             board.searches, board.hits, board.overflows);
    $display("longest text held %0d bytes, %0d load and search words sent",
             board.longest_text, sent);
    if (board.errors == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end
endmodule

[files.f]
hw/rtl/mcws_pkg.sv
hw/rtl/mcws_req_if.sv
hw/rtl/mcws_rsp_if.sv
hw/rtl/minimum_covering_window_search_core.sv
hw/rtl/mcws_checker.sv
sim/testbench.sv
